### src/sbeu_pkg.sv
// Package for the stack bytecode execute unit: sizes, type tags, command,
// error and sequencer codes, and small helper functions.
// Depends on nothing; used by stack_bytecode_execute_unit_core.
package sbeu_pkg;

  // Number of stack slots and the widths that follow from it.
  localparam int STACK_DEPTH = 256;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int SW = ((DW > 8) ? DW : 8) + 1;

  // Type tags.
  localparam logic [1:0] TAG_NIL  = 2'd0;
  localparam logic [1:0] TAG_INT  = 2'd1;
  localparam logic [1:0] TAG_BOOL = 2'd2;

  typedef enum logic [4:0] {
    CMD_NOP       = 5'd0,
    CMD_PUSH      = 5'd1,
    CMD_GETLOCAL  = 5'd2,
    CMD_SAVELOCAL = 5'd3,
    CMD_INC       = 5'd4,
    CMD_DEC       = 5'd5,
    CMD_JUMP      = 5'd6,
    CMD_JUMPFALSE = 5'd7,
    CMD_ADD       = 5'd8,
    CMD_SUB       = 5'd9,
    CMD_MUL       = 5'd10,
    CMD_DIV       = 5'd11,
    CMD_NEG       = 5'd12,
    CMD_EQ        = 5'd13,
    CMD_NE        = 5'd14,
    CMD_LT        = 5'd15,
    CMD_LE        = 5'd16,
    CMD_GT        = 5'd17,
    CMD_GE        = 5'd18,
    CMD_NOT       = 5'd19,
    CMD_AND       = 5'd20,
    CMD_OR        = 5'd21,
    CMD_ENTER     = 5'd22,
    CMD_HALT      = 5'd23
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_DIVZERO   = 3'd1,
    ERR_TYPE      = 3'd2,
    ERR_UNDEF     = 3'd3,
    ERR_UNDERFLOW = 3'd4,
    ERR_OVERFLOW  = 3'd5,
    ERR_LEFTOVER  = 3'd6
  } err_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WB,
    S_TOP,
    S_CAP
  } state_e;

  // Which multi-cycle unit, if any, finishes the operation.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV
  } op_e;

  // A value is true when it is an int or a bool and nonzero.
  function automatic logic truth_of(input logic [1:0] tag, input logic [63:0] v);
    truth_of = ((tag == TAG_INT) || (tag == TAG_BOOL)) && (v != 64'd0);
  endfunction

  // Magnitude of a two's complement word.
  function automatic logic [63:0] mag_of(input logic [63:0] v);
    mag_of = v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

### src/stack_bytecode_execute_unit_core.sv
// Execute unit of a tagged-value stack machine: one decoded command per request.
// Depends on sbeu_pkg for sizes, tags, codes and helpers.
//
// Each accepted command walks a sequencer around one synchronous stack memory
// (value and tag per slot, one read and one write port, read data registered):
// two operand reads, execute, write-back, a read of the new top of stack and
// capture into the output register. Multiply adds a state that forms its three
// 32x32 partial products, and divide adds a state for its one-bit-a-cycle
// restoring divider. A new command is taken as soon as the previous one has
// been captured, even while its result still waits on a stalled output. The
// stack memory is not cleared; only the control registers (top pointer,
// sequencer state, output valid, step counter) are reset.
module stack_bytecode_execute_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  command_i,
  input  logic [63:0] immediate_i,
  input  logic [7:0]  local_index_i,
  input  logic [15:0] jump_offset_i,
  input  logic [7:0]  frame_locals_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] top_value_o,
  output logic [1:0]  top_type_o,
  output logic [8:0]  stack_depth_o,
  output logic        branch_taken_o,
  output logic [15:0] branch_offset_o,
  output logic [2:0]  error_code_o,
  output logic        halted_o
);

  localparam int AW = sbeu_pkg::AW;
  localparam int DW = sbeu_pkg::DW;
  localparam int SW = sbeu_pkg::SW;

  // Control state.
  sbeu_pkg::state_e state_q, state_d;
  logic [DW-1:0]    d_q;
  logic             out_valid_q;
  logic [5:0]       cnt_q;

  // Latched request and operands.
  sbeu_pkg::cmd_e cmd_q;
  logic [63:0]    imm_q;
  logic [7:0]     idx_q;
  logic [15:0]    offs_q;
  logic [7:0]     nloc_q;
  logic [63:0]    a_val_q, b_val_q;
  logic [1:0]     a_tag_q, b_tag_q;

  // Execute results waiting for write-back and output.
  sbeu_pkg::err_e err_q;
  sbeu_pkg::op_e  op_q;
  logic           br_q, halt_q, wen_q;
  logic [AW-1:0]  waddr_q;
  logic [63:0]    wval_q, hv_q;
  logic [1:0]     wtag_q, ht_q;

  // Divider and multiplier registers.
  logic [63:0] quo_q, rem_q, mb_q, prod_q;
  logic        neg_q;

  // Stack memory.
  logic [65:0]   mem_q [sbeu_pkg::STACK_DEPTH];
  logic [65:0]   rdata_q;
  logic          ren;
  logic [AW-1:0] raddr;

  // Handshakes.
  logic in_acc, out_free;
  assign in_acc   = in_valid_i && (state_q == sbeu_pkg::S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sbeu_pkg::S_IDLE);

  // Read address for each read state.
  always_comb begin
    ren   = 1'b0;
    raddr = AW'(d_q - DW'(1));
    case (state_q)
      sbeu_pkg::S_IDLE: begin
        ren = in_acc;
        if ((sbeu_pkg::cmd_e'(command_i) == sbeu_pkg::CMD_GETLOCAL) ||
            (sbeu_pkg::cmd_e'(command_i) == sbeu_pkg::CMD_INC) ||
            (sbeu_pkg::cmd_e'(command_i) == sbeu_pkg::CMD_DEC)) begin
          raddr = AW'(local_index_i);
        end
      end
      sbeu_pkg::S_RDA: begin
        ren   = 1'b1;
        raddr = AW'(d_q - DW'(2));
      end
      sbeu_pkg::S_TOP: begin
        ren = 1'b1;
      end
      default: begin
        ren = 1'b0;
      end
    endcase
  end

  // Memory: synchronous read, write at write-back.
  always_ff @(posedge clk_i) begin
    if (ren) begin
      rdata_q <= mem_q[raddr];
    end
    if ((state_q == sbeu_pkg::S_WB) && wen_q) begin
      mem_q[waddr_q] <= {wtag_q, wval_q};
    end
  end

  // Execute: decide the new depth, error, branch and write for the command.
  logic           idx_ok, ii, same, lt_ab, lt_ba;
  logic [DW-1:0]  e_d;
  sbeu_pkg::err_e e_err;
  sbeu_pkg::op_e  e_op;
  logic           e_br, e_halt, e_wen;
  logic [AW-1:0]  e_waddr;
  logic [63:0]    e_wval, e_hv;
  logic [1:0]     e_wtag, e_ht;
  logic [SW-1:0]  ent_sum;

  always_comb begin
    idx_ok  = SW'(idx_q) < SW'(sbeu_pkg::STACK_DEPTH);
    ii      = (a_tag_q == sbeu_pkg::TAG_INT) && (b_tag_q == sbeu_pkg::TAG_INT);
    same    = ii || ((a_tag_q == sbeu_pkg::TAG_BOOL) && (b_tag_q == sbeu_pkg::TAG_BOOL));
    lt_ab   = $signed(a_val_q) < $signed(b_val_q);
    lt_ba   = $signed(b_val_q) < $signed(a_val_q);
    ent_sum = SW'(d_q) + SW'(nloc_q);
    e_d     = d_q;
    e_err   = sbeu_pkg::ERR_NONE;
    e_op    = sbeu_pkg::OP_NONE;
    e_br    = 1'b0;
    e_halt  = 1'b0;
    e_wen   = 1'b0;
    e_waddr = AW'(d_q - DW'(1));
    e_wval  = a_val_q;
    e_wtag  = a_tag_q;
    e_hv    = 64'd0;
    e_ht    = sbeu_pkg::TAG_NIL;
    case (cmd_q)
      sbeu_pkg::CMD_NOP: begin
        e_d = d_q;
      end
      sbeu_pkg::CMD_PUSH, sbeu_pkg::CMD_GETLOCAL: begin
        if (d_q >= DW'(sbeu_pkg::STACK_DEPTH)) begin
          e_err = sbeu_pkg::ERR_OVERFLOW;
        end else begin
          e_wen   = 1'b1;
          e_waddr = AW'(d_q);
          e_d     = d_q + DW'(1);
          if (cmd_q == sbeu_pkg::CMD_PUSH) begin
            e_wval = imm_q;
            e_wtag = sbeu_pkg::TAG_INT;
          end else if (!idx_ok) begin
            e_wval = 64'd0;
            e_wtag = sbeu_pkg::TAG_NIL;
          end
        end
      end
      sbeu_pkg::CMD_SAVELOCAL: begin
        if (d_q == DW'(0)) begin
          e_err = sbeu_pkg::ERR_UNDERFLOW;
        end else begin
          e_wen   = idx_ok;
          e_waddr = AW'(idx_q);
          e_d     = d_q - DW'(1);
        end
      end
      sbeu_pkg::CMD_INC, sbeu_pkg::CMD_DEC: begin
        e_waddr = AW'(idx_q);
        e_wval  = (cmd_q == sbeu_pkg::CMD_INC) ? (a_val_q + 64'd1) : (a_val_q - 64'd1);
        if (idx_ok && (a_tag_q == sbeu_pkg::TAG_INT)) begin
          e_wen = 1'b1;
        end else begin
          e_err = sbeu_pkg::ERR_TYPE;
        end
      end
      sbeu_pkg::CMD_JUMP: begin
        e_br = 1'b1;
      end
      sbeu_pkg::CMD_JUMPFALSE: begin
        if (d_q == DW'(0)) begin
          e_err = sbeu_pkg::ERR_UNDERFLOW;
        end else begin
          e_d  = d_q - DW'(1);
          e_br = !sbeu_pkg::truth_of(a_tag_q, a_val_q);
        end
      end
      sbeu_pkg::CMD_NEG, sbeu_pkg::CMD_NOT: begin
        if (d_q == DW'(0)) begin
          e_err = sbeu_pkg::ERR_UNDERFLOW;
        end else if (cmd_q == sbeu_pkg::CMD_NEG) begin
          e_wval = ~a_val_q + 64'd1;
          if (a_tag_q == sbeu_pkg::TAG_INT) begin
            e_wen = 1'b1;
          end else begin
            e_err = sbeu_pkg::ERR_TYPE;
          end
        end else begin
          e_wen  = 1'b1;
          e_wtag = sbeu_pkg::TAG_BOOL;
          e_wval = {63'd0, (a_tag_q == sbeu_pkg::TAG_NIL) || (a_val_q == 64'd0)};
        end
      end
      sbeu_pkg::CMD_ADD, sbeu_pkg::CMD_SUB, sbeu_pkg::CMD_MUL, sbeu_pkg::CMD_DIV,
      sbeu_pkg::CMD_EQ, sbeu_pkg::CMD_NE, sbeu_pkg::CMD_LT, sbeu_pkg::CMD_LE,
      sbeu_pkg::CMD_GT, sbeu_pkg::CMD_GE, sbeu_pkg::CMD_AND, sbeu_pkg::CMD_OR: begin
        if (d_q < DW'(2)) begin
          e_err = sbeu_pkg::ERR_UNDERFLOW;
        end else begin
          e_wen   = 1'b1;
          e_waddr = AW'(d_q - DW'(2));
          e_d     = d_q - DW'(1);
          e_wtag  = sbeu_pkg::TAG_BOOL;
          e_wval  = 64'd0;
          case (cmd_q)
            sbeu_pkg::CMD_ADD: begin
              if ((a_tag_q != sbeu_pkg::TAG_NIL && a_tag_q != sbeu_pkg::TAG_INT) ||
                  (b_tag_q != sbeu_pkg::TAG_NIL && b_tag_q != sbeu_pkg::TAG_INT)) begin
                e_wtag = sbeu_pkg::TAG_NIL;
                e_err  = sbeu_pkg::ERR_TYPE;
              end else begin
                e_wtag = sbeu_pkg::TAG_INT;
                e_wval = b_val_q + a_val_q;
              end
            end
            sbeu_pkg::CMD_SUB: begin
              e_wtag = sbeu_pkg::TAG_INT;
              e_wval = b_val_q - a_val_q;
            end
            sbeu_pkg::CMD_MUL: begin
              e_wtag = sbeu_pkg::TAG_INT;
              e_op   = sbeu_pkg::OP_MUL;
            end
            sbeu_pkg::CMD_DIV: begin
              e_wtag = sbeu_pkg::TAG_INT;
              if (a_val_q == 64'd0) begin
                e_err = sbeu_pkg::ERR_DIVZERO;
              end else begin
                e_op = sbeu_pkg::OP_DIV;
              end
            end
            sbeu_pkg::CMD_EQ: e_wval = {63'd0, same && (a_val_q == b_val_q)};
            sbeu_pkg::CMD_NE: begin
              e_wval = {63'd0, (same && (a_val_q != b_val_q)) || (a_tag_q != b_tag_q)};
            end
            sbeu_pkg::CMD_LT: e_wval = {63'd0, same && lt_ba};
            sbeu_pkg::CMD_LE: e_wval = {63'd0, same && !lt_ab};
            sbeu_pkg::CMD_GT: e_wval = {63'd0, same && lt_ab};
            sbeu_pkg::CMD_GE: e_wval = {63'd0, same && !lt_ba};
            sbeu_pkg::CMD_AND: begin
              e_wval = {63'd0, sbeu_pkg::truth_of(a_tag_q, a_val_q) &&
                               sbeu_pkg::truth_of(b_tag_q, b_val_q)};
            end
            default: begin
              e_wval = {63'd0, sbeu_pkg::truth_of(a_tag_q, a_val_q) ||
                               sbeu_pkg::truth_of(b_tag_q, b_val_q)};
            end
          endcase
        end
      end
      sbeu_pkg::CMD_ENTER: begin
        if (ent_sum > SW'(sbeu_pkg::STACK_DEPTH)) begin
          e_d   = DW'(sbeu_pkg::STACK_DEPTH);
          e_err = sbeu_pkg::ERR_OVERFLOW;
        end else begin
          e_d = DW'(ent_sum);
        end
      end
      sbeu_pkg::CMD_HALT: begin
        e_halt = 1'b1;
        if (d_q > DW'(1)) begin
          e_err = sbeu_pkg::ERR_LEFTOVER;
        end
        if (d_q > DW'(0)) begin
          e_d  = d_q - DW'(1);
          e_hv = a_val_q;
          e_ht = a_tag_q;
        end
      end
      default: begin
        e_err = sbeu_pkg::ERR_UNDEF;
      end
    endcase
  end

  // One restoring division step and the shared 32x32 multiplier.
  logic [64:0] rem_sh, diff;
  logic [63:0] quo_nx, mul_p;
  logic [31:0] mul_x, mul_y;

  always_comb begin
    rem_sh = {rem_q, quo_q[63]};
    diff   = rem_sh - {1'b0, mb_q};
    quo_nx = {quo_q[62:0], !diff[64]};
    mul_x  = (cnt_q == 6'd2) ? a_val_q[63:32] : a_val_q[31:0];
    mul_y  = (cnt_q == 6'd1) ? b_val_q[63:32] : b_val_q[31:0];
    mul_p  = {32'd0, mul_x} * {32'd0, mul_y};
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbeu_pkg::S_IDLE: if (in_acc) state_d = sbeu_pkg::S_RDA;
      sbeu_pkg::S_RDA:  state_d = sbeu_pkg::S_RDB;
      sbeu_pkg::S_RDB:  state_d = sbeu_pkg::S_EXEC;
      sbeu_pkg::S_EXEC: begin
        case (e_op)
          sbeu_pkg::OP_MUL: state_d = sbeu_pkg::S_MUL;
          sbeu_pkg::OP_DIV: state_d = sbeu_pkg::S_DIV;
          default:          state_d = sbeu_pkg::S_WB;
        endcase
      end
      sbeu_pkg::S_MUL:  if (cnt_q == 6'd3) state_d = sbeu_pkg::S_WB;
      sbeu_pkg::S_DIV:  if (cnt_q == 6'd63) state_d = sbeu_pkg::S_WB;
      sbeu_pkg::S_WB:   state_d = sbeu_pkg::S_TOP;
      sbeu_pkg::S_TOP:  state_d = sbeu_pkg::S_CAP;
      sbeu_pkg::S_CAP:  if (out_free) state_d = sbeu_pkg::S_IDLE;
      default:          state_d = sbeu_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbeu_pkg::S_IDLE;
      d_q         <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == sbeu_pkg::S_EXEC) begin
        d_q   <= e_d;
        cnt_q <= '0;
      end else if ((state_q == sbeu_pkg::S_MUL) || (state_q == sbeu_pkg::S_DIV)) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if ((state_q == sbeu_pkg::S_CAP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= sbeu_pkg::cmd_e'(command_i);
      imm_q  <= immediate_i;
      idx_q  <= local_index_i;
      offs_q <= jump_offset_i;
      nloc_q <= frame_locals_i;
    end
    if (state_q == sbeu_pkg::S_RDA) begin
      a_val_q <= rdata_q[63:0];
      a_tag_q <= rdata_q[65:64];
    end
    if (state_q == sbeu_pkg::S_RDB) begin
      b_val_q <= rdata_q[63:0];
      b_tag_q <= rdata_q[65:64];
    end
    if (state_q == sbeu_pkg::S_EXEC) begin
      err_q   <= e_err;
      op_q    <= e_op;
      br_q    <= e_br;
      halt_q  <= e_halt;
      wen_q   <= e_wen;
      waddr_q <= e_waddr;
      wval_q  <= e_wval;
      wtag_q  <= e_wtag;
      hv_q    <= e_hv;
      ht_q    <= e_ht;
      quo_q   <= sbeu_pkg::mag_of(b_val_q);
      mb_q    <= sbeu_pkg::mag_of(a_val_q);
      rem_q   <= 64'd0;
      neg_q   <= a_val_q[63] ^ b_val_q[63];
    end
    // Multiply: three partial products, each added in the cycle after it is formed.
    if (state_q == sbeu_pkg::S_MUL) begin
      prod_q <= mul_p;
      if (cnt_q == 6'd1) begin
        wval_q <= prod_q;
      end else if (cnt_q != 6'd0) begin
        wval_q <= wval_q + {prod_q[31:0], 32'd0};
      end
    end
    // Divide: one quotient bit a cycle on the magnitudes, sign fixed at the end.
    if (state_q == sbeu_pkg::S_DIV) begin
      quo_q <= quo_nx;
      rem_q <= diff[64] ? rem_sh[63:0] : diff[63:0];
      if (cnt_q == 6'd63) begin
        wval_q <= neg_q ? (~quo_nx + 64'd1) : quo_nx;
      end
    end
    // Result capture once the output register is free.
    if ((state_q == sbeu_pkg::S_CAP) && out_free) begin
      if (halt_q) begin
        top_value_o <= hv_q;
        top_type_o  <= ht_q;
      end else if (d_q == DW'(0)) begin
        top_value_o <= 64'd0;
        top_type_o  <= sbeu_pkg::TAG_NIL;
      end else begin
        top_value_o <= rdata_q[63:0];
        top_type_o  <= rdata_q[65:64];
      end
      stack_depth_o   <= 9'(d_q);
      branch_taken_o  <= br_q;
      branch_offset_o <= br_q ? offs_q : 16'd0;
      error_code_o    <= err_q;
      halted_o        <= halt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Memory is written only at write-back; a divide write-back is never flagged as halt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbeu_pkg::S_WB) && wen_q |-> op_q != sbeu_pkg::OP_DIV || !halt_q)
    else $error("divide write-back flagged as halt");

  // Depth never passes the stack size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_q <= DW'(sbeu_pkg::STACK_DEPTH))
    else $error("stack depth beyond stack size");

  // An accepted request always starts the read sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == sbeu_pkg::S_RDA)
    else $error("accepted request did not start");

  // A halting result never reports a branch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> !branch_taken_o)
    else $error("halt reported together with a branch");

  // The divider finishes after exactly 64 steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbeu_pkg::S_DIV) && (cnt_q == 6'd63) |=> state_q == sbeu_pkg::S_WB)
    else $error("divider did not finish on time");

endmodule
